/* rtl/core/mpeg4_vol_header_parser_core_assert.svh */
// ----------------------------------------------------------------------------
// mpeg4_vol_header_parser_core_assert
// assertion macros for the vol header parser
// ----------------------------------------------------------------------------
`ifndef MPEG4_VOL_HEADER_PARSER_CORE_ASSERT_SVH
`define MPEG4_VOL_HEADER_PARSER_CORE_ASSERT_SVH
// property must hold on every clock edge out of reset
`define VHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define VHP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/core/vhp_pkg.sv */
// ----------------------------------------------------------------------------
// vhp_pkg
// shared types, step codes and field widths of the vol header parser
// ----------------------------------------------------------------------------
package vhp_pkg;

  typedef enum logic [4:0] {
    ST_IDLE = 5'd0, ST_RA = 5'd1, ST_VOTI = 5'd2, ST_ISID = 5'd3,
    ST_VERID = 5'd4, ST_PRIO = 5'd5, ST_ARI = 5'd6, ST_PARW = 5'd7,
    ST_PARH = 5'd8, ST_CTRL = 5'd9, ST_CHROMA = 5'd10, ST_LOWD = 5'd11,
    ST_VBVF = 5'd12, ST_VBV1 = 5'd13, ST_VBV2 = 5'd14, ST_VBV3 = 5'd15,
    ST_VBV4 = 5'd16, ST_VBV5 = 5'd17, ST_SHAPE = 5'd18, ST_SHEXT = 5'd19,
    ST_MK1 = 5'd20, ST_RES = 5'd21, ST_MK2 = 5'd22, ST_FIXED = 5'd23,
    ST_INC = 5'd24, ST_MW = 5'd25, ST_W = 5'd26, ST_MH = 5'd27,
    ST_H = 5'd28
  } step_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0, PEND_TYPE = 2'd1, PEND_PROF = 2'd2, PEND_VOP = 2'd3
  } pend_e;

  typedef enum logic [1:0] {
    CS_IDLE = 2'd0, CS_BITS = 2'd1, CS_DIV = 2'd2, CS_OUT = 2'd3
  } ctl_e;

  localparam logic [7:0] SC_VOS = 8'hB0;
  localparam logic [7:0] SC_VO  = 8'hB5;
  localparam logic [7:0] SC_VOP = 8'hB6;
  localparam logic [7:0] SC_UD  = 8'hB2;
  localparam logic [7:0] SC_VOL = 8'h20;
  localparam logic [3:0] ARI_EXT = 4'd15;
  localparam int unsigned DivW = 16;

  typedef struct packed {
    logic start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  function automatic logic [4:0] step_bits(input step_e s);
    unique case (s) inside
      ST_RA, ST_ISID, ST_CTRL, ST_LOWD, ST_VBVF, ST_MK1, ST_MK2, ST_FIXED, ST_MW,
      ST_MH: return 5'd1;
      ST_VOTI, ST_PARW, ST_PARH: return 5'd8;
      ST_VERID, ST_ARI, ST_SHEXT: return 5'd4;
      ST_PRIO: return 5'd3;
      ST_CHROMA, ST_SHAPE: return 5'd2;
      ST_VBV1, ST_VBV2, ST_VBV3, ST_VBV5, ST_RES: return 5'd16;
      ST_VBV4: return 5'd15;
      ST_W, ST_H: return 5'd13;
      default: return 5'd0;
    endcase
  endfunction

endpackage

/* rtl/core/mpeg4_vol_header_parser_core.sv */
// ----------------------------------------------------------------------------
// mpeg4_vol_header_parser_core
// mpeg-4 part 2 start code scan and vol header field extraction
// ----------------------------------------------------------------------------
// Takes one stream byte per request and returns one result on the byte
// flagged last. An accepted byte is then shifted out bit by bit, up to
// eight header bits, with a closing step when the field parse goes idle
// before the eighth bit; a video object layer type byte restarts the parse
// on acceptance and consumes no bits. A byte that completes a nonzero fixed
// increment then waits on the radix-2 divider for the frame rate, and the
// last byte passes through a load state that fills the output register,
// which then holds off new requests until taken.
// The bit loop shifts field bits MSB-first through one accumulator.
module mpeg4_vol_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        is_mpeg4_o,
  output logic        key_frame_o,
  output logic        stream_info_o,
  output logic [7:0]  profile_level_o,
  output logic [1:0]  layer_shape_o,
  output logic [15:0] time_resolution_o,
  output logic        fixed_rate_o,
  output logic [15:0] fixed_increment_o,
  output logic [15:0] frame_rate_o,
  output logic [12:0] frame_width_o,
  output logic [12:0] frame_height_o,
  output logic        chroma_420_o
);
  `include "mpeg4_vol_header_parser_core_assert.svh"

  vhp_pkg::ctl_e  cs_q, cs_d;
  vhp_pkg::step_e step_q, step_d;
  vhp_pkg::pend_e pend_q, pend_d;
  logic [15:0] hist_q, hist_d;
  logic [4:0]  left_q, left_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;        // next bit position
  logic        last_q, last_d;
  // parse state
  logic [3:0]  verid_q, verid_d;
  logic [1:0]  shape_q, shape_d;
  logic        mp4_q, mp4_d, key_q, key_d, strm_q, strm_d, fix_q, fix_d, chr_q, chr_d;
  logic [7:0]  prof_q, prof_d;
  logic [1:0]  rshape_q, rshape_d;
  logic [15:0] res_q, res_d, inc_q, inc_d, rate_q, rate_d;
  logic [12:0] wpend_q, wpend_d, w_q, w_d, h_q, h_d;
  // output register
  logic        ov_q, ov_d;

  vhp_pkg::div_req_t div_req;
  logic        div_busy;
  logic [15:0] div_quot;

  vhp_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(div_req),
    .busy_o(div_busy), .quot_o(div_quot)
  );

  logic [15:0] acc_n;
  logic [15:0] rm1;
  logic [4:0]  inc_bits;
  logic        bit_v;

  // bit length of resolution minus one, for the increment field
  always_comb begin
    rm1 = res_q - 16'd1;
    inc_bits = 5'd1;
    for (int i = 0; i < 16; i++) if (rm1[i]) inc_bits = 5'(i + 1);
  end

  assign stall_o = (cs_q != vhp_pkg::CS_IDLE) || ov_q;
  assign bit_v = byte_q[bit_q];
  assign acc_n = {acc_q[14:0], bit_v};

  always_comb begin
    cs_d = cs_q; step_d = step_q; pend_d = pend_q; hist_d = hist_q;
    left_d = left_q; acc_d = acc_q; byte_d = byte_q; bit_d = bit_q;
    last_d = last_q; verid_d = verid_q; shape_d = shape_q; mp4_d = mp4_q;
    key_d = key_q; strm_d = strm_q; fix_d = fix_q; chr_d = chr_q;
    prof_d = prof_q; rshape_d = rshape_q; res_d = res_q; inc_d = inc_q;
    rate_d = rate_q; wpend_d = wpend_q; w_d = w_q; h_d = h_q;
    ov_d = ov_q && stall_i;
    div_req = '{start: 1'b0, num: res_q, den: inc_q};

    unique case (cs_q)
      vhp_pkg::CS_IDLE: begin
        if (valid_i && !stall_o) begin
          byte_d = data_byte_i; last_d = last_i; bit_d = 3'd7;
          pend_d = vhp_pkg::PEND_NONE;
          cs_d = vhp_pkg::CS_BITS;
          unique case (pend_q)
            vhp_pkg::PEND_PROF: prof_d = data_byte_i;
            vhp_pkg::PEND_VOP: if (data_byte_i[7:6] == 2'b00) key_d = 1'b1;
            vhp_pkg::PEND_TYPE: begin
              if (data_byte_i == vhp_pkg::SC_VOS || data_byte_i == vhp_pkg::SC_VO ||
                  data_byte_i == vhp_pkg::SC_VOP || data_byte_i == vhp_pkg::SC_UD ||
                  data_byte_i[7:4] == vhp_pkg::SC_VOL[7:4]) mp4_d = 1'b1;
              if (data_byte_i == vhp_pkg::SC_VOL) begin
                strm_d = 1'b1; key_d = 1'b1; verid_d = '0;
                step_d = vhp_pkg::ST_RA; acc_d = '0;
                left_d = vhp_pkg::step_bits(vhp_pkg::ST_RA);
                cs_d = last_i ? vhp_pkg::CS_OUT : vhp_pkg::CS_IDLE;
              end else if (data_byte_i == vhp_pkg::SC_VOS) begin
                key_d = 1'b1; pend_d = vhp_pkg::PEND_PROF;
              end else if (data_byte_i == vhp_pkg::SC_VOP) begin
                pend_d = vhp_pkg::PEND_VOP;
              end
            end
            default: ;
          endcase
          if (data_byte_i == 8'h01 && hist_q == 16'h0000) pend_d = vhp_pkg::PEND_TYPE;
          hist_d = {hist_q[7:0], data_byte_i};
        end
      end
      vhp_pkg::CS_BITS: begin
        if (step_q == vhp_pkg::ST_IDLE || left_q == '0) begin
          cs_d = last_q ? vhp_pkg::CS_OUT : vhp_pkg::CS_IDLE;
        end else begin
          logic [4:0] nl;
          vhp_pkg::step_e ns;
          logic done_go;
          nl = left_q - 5'd1;
          acc_d = acc_n; left_d = nl; bit_d = bit_q - 3'd1;
          ns = vhp_pkg::ST_IDLE; done_go = 1'b0;
          if (nl == '0) begin
            done_go = 1'b1;
            unique case (step_q) inside
              vhp_pkg::ST_ISID: ns = acc_n[0] ? vhp_pkg::ST_VERID : vhp_pkg::ST_ARI;
              vhp_pkg::ST_VERID: begin verid_d = acc_n[3:0]; ns = vhp_pkg::ST_PRIO; end
              vhp_pkg::ST_PRIO: ns = vhp_pkg::ST_ARI;
              vhp_pkg::ST_ARI, vhp_pkg::ST_PARH: begin
                if (step_q == vhp_pkg::ST_ARI && acc_n[3:0] == vhp_pkg::ARI_EXT) begin
                  ns = vhp_pkg::ST_PARW;
                end else begin
                  chr_d = 1'b0; ns = vhp_pkg::ST_CTRL;
                end
              end
              vhp_pkg::ST_CTRL: ns = acc_n[0] ? vhp_pkg::ST_CHROMA : vhp_pkg::ST_SHAPE;
              vhp_pkg::ST_CHROMA: begin
                chr_d = (acc_n[1:0] == 2'd1); ns = vhp_pkg::ST_LOWD;
              end
              vhp_pkg::ST_VBVF: ns = acc_n[0] ? vhp_pkg::ST_VBV1 : vhp_pkg::ST_SHAPE;
              vhp_pkg::ST_VBV5: ns = vhp_pkg::ST_SHAPE;
              vhp_pkg::ST_SHAPE: begin
                shape_d = acc_n[1:0]; rshape_d = acc_n[1:0];
                ns = (acc_n[1:0] == 2'd3 && verid_q != 4'd1) ?
                     vhp_pkg::ST_SHEXT : vhp_pkg::ST_MK1;
              end
              vhp_pkg::ST_RES: begin res_d = acc_n; ns = vhp_pkg::ST_MK2; end
              vhp_pkg::ST_FIXED: begin
                if (acc_n[0]) begin
                  fix_d = 1'b1; ns = vhp_pkg::ST_INC;
                end else begin
                  ns = (shape_q == 2'd0) ? vhp_pkg::ST_MW : vhp_pkg::ST_IDLE;
                end
              end
              vhp_pkg::ST_INC: begin
                inc_d = acc_n;
                ns = (shape_q == 2'd0) ? vhp_pkg::ST_MW : vhp_pkg::ST_IDLE;
                if (acc_n != '0) begin
                  div_req = '{start: 1'b1, num: res_q, den: acc_n};
                  cs_d = vhp_pkg::CS_DIV;
                end
              end
              vhp_pkg::ST_W: begin wpend_d = acc_n[12:0]; ns = vhp_pkg::ST_MH; end
              vhp_pkg::ST_H: begin
                w_d = wpend_q; h_d = acc_n[12:0]; ns = vhp_pkg::ST_IDLE;
              end
              vhp_pkg::ST_IDLE: ns = vhp_pkg::ST_IDLE;
              default: ns = vhp_pkg::step_e'(step_q + 5'd1);
            endcase
          end
          if (done_go) begin
            step_d = ns; acc_d = '0;
            left_d = (ns == vhp_pkg::ST_INC) ? inc_bits : vhp_pkg::step_bits(ns);
          end
          if (bit_q == 3'd0 && cs_d == vhp_pkg::CS_BITS)
            cs_d = last_q ? vhp_pkg::CS_OUT : vhp_pkg::CS_IDLE;
        end
      end
      vhp_pkg::CS_DIV: begin
        if (!div_busy) begin
          rate_d = div_quot;
          cs_d = (bit_q == 3'd7) ? (last_q ? vhp_pkg::CS_OUT : vhp_pkg::CS_IDLE)
                                 : vhp_pkg::CS_BITS;
        end
      end
      vhp_pkg::CS_OUT: begin
        ov_d = 1'b1;
        cs_d = vhp_pkg::CS_IDLE;
      end
      default: cs_d = vhp_pkg::CS_IDLE;
    endcase
  end

  // output register, loaded when the last byte has been parsed
  always_ff @(posedge clk_i) begin
    if (cs_q == vhp_pkg::CS_OUT) begin
      is_mpeg4_o        <= mp4_q;
      key_frame_o       <= mp4_q & key_q;
      stream_info_o     <= mp4_q & strm_q;
      profile_level_o   <= mp4_q ? prof_q : '0;
      layer_shape_o     <= mp4_q ? rshape_q : '0;
      time_resolution_o <= mp4_q ? res_q : '0;
      fixed_rate_o      <= mp4_q & fix_q;
      fixed_increment_o <= mp4_q ? inc_q : '0;
      frame_rate_o      <= mp4_q ? rate_q : '0;
      frame_width_o     <= mp4_q ? w_q : '0;
      frame_height_o    <= mp4_q ? h_q : '0;
      chroma_420_o      <= mp4_q & chr_q;
    end
  end
  assign valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= vhp_pkg::CS_IDLE; ov_q <= 1'b0;
    end else begin
      cs_q <= cs_d; ov_q <= ov_d;
    end
  end

  // parse state returns to reset after each delivered buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= vhp_pkg::ST_IDLE; pend_q <= vhp_pkg::PEND_NONE; hist_q <= '0;
      left_q <= '0; acc_q <= '0; byte_q <= '0; bit_q <= '0; last_q <= 1'b0;
      verid_q <= '0; shape_q <= '0; mp4_q <= 1'b0; key_q <= 1'b0; strm_q <= 1'b0;
      fix_q <= 1'b0; chr_q <= 1'b0; prof_q <= '0; rshape_q <= '0; res_q <= '0;
      inc_q <= '0; rate_q <= '0; wpend_q <= '0; w_q <= '0; h_q <= '0;
    end else if (cs_q == vhp_pkg::CS_OUT) begin
      step_q <= vhp_pkg::ST_IDLE; pend_q <= vhp_pkg::PEND_NONE; hist_q <= '0;
      left_q <= '0; acc_q <= '0; last_q <= 1'b0;
      verid_q <= '0; shape_q <= '0; mp4_q <= 1'b0; key_q <= 1'b0; strm_q <= 1'b0;
      fix_q <= 1'b0; chr_q <= 1'b0; prof_q <= '0; rshape_q <= '0; res_q <= '0;
      inc_q <= '0; rate_q <= '0; wpend_q <= '0; w_q <= '0; h_q <= '0;
    end else begin
      step_q <= step_d; pend_q <= pend_d; hist_q <= hist_d; left_q <= left_d;
      acc_q <= acc_d; byte_q <= byte_d; bit_q <= bit_d; last_q <= last_d;
      verid_q <= verid_d; shape_q <= shape_d; mp4_q <= mp4_d; key_q <= key_d;
      strm_q <= strm_d; fix_q <= fix_d; chr_q <= chr_d; prof_q <= prof_d;
      rshape_q <= rshape_d; res_q <= res_d; inc_q <= inc_d; rate_q <= rate_d;
      wpend_q <= wpend_d; w_q <= w_d; h_q <= h_d;
    end
  end

  `VHP_ASSERT(a_out_only_from_load, !valid_o || $past(cs_q) == vhp_pkg::CS_OUT || $past(valid_o))
  `VHP_ASSERT_NEXT(a_load_gives_result, cs_q == vhp_pkg::CS_OUT, valid_o)
  `VHP_ASSERT(a_div_only_in_div, !div_busy || cs_q == vhp_pkg::CS_DIV)
  `VHP_ASSERT_NEXT(a_busy_blocks, cs_q != vhp_pkg::CS_IDLE, stall_o || cs_q == vhp_pkg::CS_IDLE)
endmodule

/* rtl/core/vhp_divider.sv */
// ----------------------------------------------------------------------------
// vhp_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vhp_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vhp_pkg::div_req_t        req_i,
  output logic                     busy_o,
  output logic [vhp_pkg::DivW-1:0] quot_o
);
  localparam int unsigned W = vhp_pkg::DivW;
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [$clog2(W+1)-1:0] cnt_q, cnt_d;
  logic [W:0] trial;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (req_i.start) begin
      rem_d = '0; quo_d = req_i.num; den_d = req_i.den;
      cnt_d = ($clog2(W+1))'(W);
    end else if (cnt_q != '0) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mpeg-4 vol header parser core
// ----------------------------------------------------------------------------
// Feeds byte streams (well-formed VOL headers with random field content, VOS
// and VOP start codes, truncated buffers and noise) through the request
// channel. An in-bench parser predicts each result on the last byte, and the
// monitor compares it as a whole with the oldest prediction.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } req_t;

  typedef struct packed {
    logic        is_mpeg4;
    logic        key_frame;
    logic        stream_info;
    logic [7:0]  profile_level;
    logic [1:0]  layer_shape;
    logic [15:0] time_resolution;
    logic        fixed_rate;
    logic [15:0] fixed_increment;
    logic [15:0] frame_rate;
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic        chroma_420;
  } hdr_info_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic stall_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic last_i = 1'b0;
  logic stall_o, valid_o;
  logic in_taken = 1'b0;
  hdr_info_t got;

  always #6 clk_i = ~clk_i;

  mpeg4_vol_header_parser_core u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .data_byte_i, .last_i, .valid_o, .stall_i,
    .is_mpeg4_o(got.is_mpeg4), .key_frame_o(got.key_frame),
    .stream_info_o(got.stream_info), .profile_level_o(got.profile_level),
    .layer_shape_o(got.layer_shape), .time_resolution_o(got.time_resolution),
    .fixed_rate_o(got.fixed_rate), .fixed_increment_o(got.fixed_increment),
    .frame_rate_o(got.frame_rate), .frame_width_o(got.frame_width),
    .frame_height_o(got.frame_height), .chroma_420_o(got.chroma_420)
  );

  // ---------------- parser prediction state ----------------
  logic [15:0]    hist;
  vhp_pkg::pend_e pend;
  vhp_pkg::step_e step;
  logic [4:0]     bits_left;
  logic [15:0]    accum;
  logic [3:0]     verid;
  logic [1:0]     shape_sv;
  logic           f_mp4, f_key, f_stream, f_fixed, f_chroma;
  logic [7:0]     r_prof;
  logic [1:0]     r_shape;
  logic [15:0]    r_res, r_inc, r_rate, div_res;
  logic [12:0]    r_w, r_h, pend_w;

  req_t      pending_reqs[$];
  hdr_info_t expected_hdrs[$];
  int        errors = 0;
  int        n_results = 0;
  int        n_bytes = 0;
  bit        hold_sender = 1'b0;
  longint    cycles = 0;

  function automatic logic [4:0] field_len(vhp_pkg::step_e s);
    case (s) inside
      vhp_pkg::ST_RA, vhp_pkg::ST_ISID, vhp_pkg::ST_CTRL, vhp_pkg::ST_LOWD,
      vhp_pkg::ST_VBVF, vhp_pkg::ST_MK1, vhp_pkg::ST_MK2, vhp_pkg::ST_FIXED,
      vhp_pkg::ST_MW, vhp_pkg::ST_MH: return 5'd1;
      vhp_pkg::ST_VOTI, vhp_pkg::ST_PARW, vhp_pkg::ST_PARH: return 5'd8;
      vhp_pkg::ST_VERID, vhp_pkg::ST_ARI, vhp_pkg::ST_SHEXT: return 5'd4;
      vhp_pkg::ST_PRIO: return 5'd3;
      vhp_pkg::ST_CHROMA, vhp_pkg::ST_SHAPE: return 5'd2;
      vhp_pkg::ST_VBV1, vhp_pkg::ST_VBV2, vhp_pkg::ST_VBV3, vhp_pkg::ST_VBV5,
      vhp_pkg::ST_RES: return 5'd16;
      vhp_pkg::ST_VBV4: return 5'd15;
      vhp_pkg::ST_W, vhp_pkg::ST_H: return 5'd13;
      default: return 5'd0;
    endcase
  endfunction

  function automatic void clear_parser();
    hist = '0; pend = vhp_pkg::PEND_NONE; step = vhp_pkg::ST_IDLE; bits_left = '0;
    accum = '0; verid = '0; shape_sv = '0; f_mp4 = 0; f_key = 0; f_stream = 0;
    f_fixed = 0; f_chroma = 0; r_prof = '0; r_shape = '0; r_res = '0; r_inc = '0;
    r_rate = '0; div_res = '0; r_w = '0; r_h = '0; pend_w = '0;
  endfunction

  function automatic void enter_step(vhp_pkg::step_e s);
    logic [15:0] r;
    int n;
    step = s;
    accum = '0;
    if (s == vhp_pkg::ST_INC) begin
      r = div_res - 16'd1;
      n = 0;
      while (r != 0) begin
        n++;
        r = r >> 1;
      end
      bits_left = (n == 0) ? 5'd1 : 5'(n);
    end else begin
      bits_left = field_len(s);
    end
  endfunction

  function automatic void after_fixed_flag();
    if (shape_sv == 2'd0) enter_step(vhp_pkg::ST_MW);
    else enter_step(vhp_pkg::ST_IDLE);
  endfunction

  function automatic void close_field(logic [15:0] v);
    case (step) inside
      vhp_pkg::ST_ISID: enter_step(v != 0 ? vhp_pkg::ST_VERID : vhp_pkg::ST_ARI);
      vhp_pkg::ST_VERID: begin
        verid = v[3:0];
        enter_step(vhp_pkg::ST_PRIO);
      end
      vhp_pkg::ST_PRIO: enter_step(vhp_pkg::ST_ARI);
      vhp_pkg::ST_ARI, vhp_pkg::ST_PARH: begin
        if (step == vhp_pkg::ST_ARI && v == 16'(vhp_pkg::ARI_EXT))
          enter_step(vhp_pkg::ST_PARW);
        else begin
          // chroma flag drops whenever the control flag is reached
          f_chroma = 1'b0;
          enter_step(vhp_pkg::ST_CTRL);
        end
      end
      vhp_pkg::ST_CTRL: enter_step(v != 0 ? vhp_pkg::ST_CHROMA : vhp_pkg::ST_SHAPE);
      vhp_pkg::ST_CHROMA: begin
        f_chroma = (v == 16'd1);
        enter_step(vhp_pkg::ST_LOWD);
      end
      vhp_pkg::ST_VBVF: enter_step(v != 0 ? vhp_pkg::ST_VBV1 : vhp_pkg::ST_SHAPE);
      vhp_pkg::ST_VBV5: enter_step(vhp_pkg::ST_SHAPE);
      vhp_pkg::ST_SHAPE: begin
        shape_sv = v[1:0];
        r_shape = v[1:0];
        if (v == 16'd3 && verid != 4'd1) enter_step(vhp_pkg::ST_SHEXT);
        else enter_step(vhp_pkg::ST_MK1);
      end
      vhp_pkg::ST_RES: begin
        r_res = v;
        div_res = v;
        enter_step(vhp_pkg::ST_MK2);
      end
      vhp_pkg::ST_FIXED: begin
        if (v != 0) begin
          f_fixed = 1'b1;
          enter_step(vhp_pkg::ST_INC);
        end else after_fixed_flag();
      end
      vhp_pkg::ST_INC: begin
        r_inc = v;
        if (v != 0) r_rate = div_res / v;
        after_fixed_flag();
      end
      vhp_pkg::ST_W: begin
        pend_w = v[12:0];
        enter_step(vhp_pkg::ST_MH);
      end
      vhp_pkg::ST_H: begin
        r_w = pend_w;
        r_h = v[12:0];
        enter_step(vhp_pkg::ST_IDLE);
      end
      default: begin
        if (step > vhp_pkg::ST_IDLE && step < vhp_pkg::ST_H)
          enter_step(vhp_pkg::step_e'(step + 5'd1));
        else enter_step(vhp_pkg::ST_IDLE);
      end
    endcase
  endfunction

  // advances the parser by one byte; returns 1 with a header on the last byte
  function automatic bit parse_byte(req_t q, output hdr_info_t h);
    vhp_pkg::pend_e p;
    bit restart;
    p = pend;
    restart = 0;
    pend = vhp_pkg::PEND_NONE;
    h = '0;
    case (p)
      vhp_pkg::PEND_PROF: r_prof = q.data;
      vhp_pkg::PEND_VOP: if ((q.data & 8'hC0) == 8'h00) f_key = 1'b1;
      vhp_pkg::PEND_TYPE: begin
        if (q.data == vhp_pkg::SC_VOS || q.data == vhp_pkg::SC_VO ||
            q.data == vhp_pkg::SC_VOP || q.data == vhp_pkg::SC_UD ||
            (q.data & 8'hF0) == vhp_pkg::SC_VOL) f_mp4 = 1'b1;
        if (q.data == vhp_pkg::SC_VOL) begin
          f_stream = 1'b1;
          f_key = 1'b1;
          verid = '0;
          restart = 1;
        end else if (q.data == vhp_pkg::SC_VOS) begin
          f_key = 1'b1;
          pend = vhp_pkg::PEND_PROF;
        end else if (q.data == vhp_pkg::SC_VOP) pend = vhp_pkg::PEND_VOP;
      end
      default: ;
    endcase
    if (q.data == 8'h01 && hist == 16'h0000) pend = vhp_pkg::PEND_TYPE;
    if (restart) enter_step(vhp_pkg::ST_RA);
    else begin
      for (int i = 7; i >= 0; i--) begin
        if (step == vhp_pkg::ST_IDLE || bits_left == 0) break;
        accum = {accum[14:0], q.data[i]};
        bits_left--;
        if (bits_left == 0) close_field(accum);
      end
    end
    hist = {hist[7:0], q.data};
    if (!q.last) return 0;
    if (f_mp4) begin
      h = '{1'b1, f_key, f_stream, r_prof, r_shape, r_res, f_fixed, r_inc, r_rate,
            r_w, r_h, f_chroma};
    end
    clear_parser();
    return 1;
  endfunction

  // ---------------- stimulus building ----------------
  logic [7:0] bitbuf[$];
  logic [7:0] cur_byte;
  int         cur_n;

  task automatic put_bits(logic [31:0] v, int n);
    for (int i = n - 1; i >= 0; i--) begin
      cur_byte = {cur_byte[6:0], v[i]};
      cur_n++;
      if (cur_n == 8) begin
        bitbuf = {bitbuf, cur_byte};
        cur_n = 0;
        cur_byte = '0;
      end
    end
  endtask

  task automatic push_bytes(logic [7:0] bs[$], bit end_buf);
    req_t r;
    foreach (bs[i]) begin
      r.data = bs[i];
      r.last = end_buf && i == bs.size() - 1;
      pending_reqs = {pending_reqs, r};
    end
  endtask

  task automatic put_sc(logic [7:0] t);
    put_bits(32'h00000100 | 32'(t), 32);
  endtask

  // builds a vol header bit by bit with chosen fields, random elsewhere
  task automatic put_vol(logic [15:0] res, logic fixed, logic [15:0] inc,
                         logic [1:0] shp, logic [12:0] w, logic [12:0] h);
    logic [15:0] r;
    int nb;
    bit isid, ctrl, vbv;
    logic [3:0] vid, ari;
    put_sc(vhp_pkg::SC_VOL);
    put_bits($urandom, 9);
    isid = 1'($urandom_range(1));
    put_bits(32'(isid), 1);
    vid = 4'($urandom);
    if (isid) put_bits(32'({vid, 3'($urandom)}), 7);
    ari = ($urandom_range(3) == 0) ? vhp_pkg::ARI_EXT : 4'($urandom);
    put_bits(32'(ari), 4);
    if (ari == vhp_pkg::ARI_EXT) put_bits($urandom, 16);
    ctrl = 1'($urandom_range(1));
    put_bits(32'(ctrl), 1);
    if (ctrl) begin
      put_bits($urandom, 3);
      vbv = 1'($urandom_range(1));
      put_bits(32'(vbv), 1);
      if (vbv) begin
        put_bits($urandom, 32);
        put_bits($urandom, 32);
        put_bits($urandom, 15);
      end
    end
    put_bits(32'(shp), 2);
    if (shp == 2'd3 && !(isid && vid == 4'd1)) put_bits($urandom, 4);
    put_bits(32'({1'b1, res, 1'b1, fixed}), 19);
    if (fixed) begin
      r = res - 16'd1;
      nb = 0;
      while (r != 0) begin
        nb++;
        r = r >> 1;
      end
      if (nb == 0) nb = 1;
      put_bits(32'(inc), nb);
    end
    if (shp == 2'd0) put_bits(32'({1'b1, w, 1'b1, h}), 28);
    put_bits($urandom, 8);
  endtask

  // one buffer: headers, start codes and noise in random order
  task automatic random_buffer();
    int parts;
    logic [15:0] res;
    bitbuf.delete();
    cur_n = 0;
    cur_byte = '0;
    parts = $urandom_range(1, 3);
    repeat (parts) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          res = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
          put_vol(res, 1'($urandom_range(1)), 16'($urandom), 2'($urandom),
                  13'($urandom), 13'($urandom));
        end
        5: begin
          put_sc(vhp_pkg::SC_VOS);
          put_bits($urandom, 8);
        end
        6: begin
          put_sc(vhp_pkg::SC_VOP);
          put_bits($urandom, 8);
        end
        7: put_sc($urandom_range(1) ? vhp_pkg::SC_VO : vhp_pkg::SC_UD);
        8: put_sc(8'($urandom));
        default: repeat ($urandom_range(1, 6)) put_bits($urandom_range(2) ? $urandom : 0, 8);
      endcase
      if (cur_n != 0) put_bits(0, 8 - cur_n);
    end
    // sometimes chop the buffer to leave a field incomplete
    if ($urandom_range(4) == 0 && bitbuf.size() > 2)
      bitbuf = bitbuf[0:$urandom_range(1, bitbuf.size() - 1)];
    push_bytes(bitbuf, 1);
  endtask

  task automatic one_vol(logic [15:0] res, logic fx, logic [15:0] inc, logic [1:0] shp,
                         logic [12:0] w, logic [12:0] h);
    bitbuf.delete();
    cur_n = 0;
    cur_byte = '0;
    put_vol(res, fx, inc, shp, w, h);
    push_bytes(bitbuf, 1);
  endtask

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    // a request on the wire stays until it has been taken
    if (rst_ni && (!valid_i || in_taken)) begin
      if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
        valid_i <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        req_t q;
        q = pending_reqs.pop_front();
        valid_i <= 1'b1;
        data_byte_i <= q.data;
        last_i <= q.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(0, 6);
        end else burst_left <= burst_left - 1;
      end
    end
  end

  // receiver stall pattern: phases of free flow and of random stalls
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 300;
    stall_i <= (stall_phase < 100) ? 1'b0 : ($urandom_range(2) == 0);
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      in_taken <= valid_i && !stall_o;
      // request accepted: step the parser
      if (valid_i && !stall_o) begin
        hdr_info_t h;
        n_bytes <= n_bytes + 1;
        if (parse_byte('{data_byte_i, last_i}, h)) expected_hdrs = {expected_hdrs, h};
      end
      if (valid_o && !stall_i) begin
        n_results <= n_results + 1;
        if (expected_hdrs.size() == 0) begin
          $display("%0t: unexpected result %p", $time, got);
          errors <= errors + 1;
        end else begin
          hdr_info_t e;
          e = expected_hdrs.pop_front();
          if (got !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, got);
            errors <= errors + 1;
          end
        end
      end
      if (cycles > 3000000) begin
        $display("%0t: timeout", $time);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    clear_parser();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: field extremes, shapes, zero increment, zero resolution
    one_vol(16'd30000, 1, 16'd1001, 2'd0, 13'd1920, 13'd1080);
    one_vol(16'hFFFF, 1, 16'hFFFF, 2'd0, 13'h1FFF, 13'h1FFF);
    one_vol(16'd0, 1, 16'd0, 2'd1, 0, 0);
    one_vol(16'd1, 1, 16'd1, 2'd3, 0, 0);
    one_vol(16'd25, 0, 0, 2'd2, 0, 0);
    push_bytes('{8'h00, 8'h00, 8'h01, vhp_pkg::SC_VOS, 8'hFF, 8'h00, 8'h00, 8'h01,
                 vhp_pkg::SC_VOP, 8'h3F}, 1);
    push_bytes('{8'h00, 8'h00, 8'h01, vhp_pkg::SC_VOP, 8'hC0, 8'h00, 8'h00, 8'h01,
                 vhp_pkg::SC_UD}, 1);
    // start code ending the buffer, overlapping codes, non-mpeg buffer
    push_bytes('{8'h00, 8'h00, 8'h00, 8'h01, vhp_pkg::SC_VOS}, 1);
    push_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h2F}, 1);
    push_bytes('{8'h00, 8'h00, 8'h01, 8'h47, 8'hFF}, 1);
    push_bytes('{8'h00}, 1);
    while (pending_reqs.size() != 0 || valid_i || expected_hdrs.size() != 0)
      @(posedge clk_i);
    // once everything has drained, the sender holds off while buffers are queued
    hold_sender = 1'b1;
    repeat (20) random_buffer();
    repeat (30) @(posedge clk_i);
    hold_sender = 1'b0;
    while (pending_reqs.size() + n_bytes < 1600) random_buffer();
    while (pending_reqs.size() != 0 || valid_i || expected_hdrs.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d stream bytes and %0d header results", n_bytes, n_results);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
